>>> src/double_ended_queue_macros.svh
// Assertion helpers used by the queue datapath.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue assertion failed");

`endif

>>> src/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    localparam int WORD_W = 32;

    typedef logic [2:0] mode_t;
    typedef logic [1:0] status_t;

    localparam mode_t MODE_PUSH_FRONT = 3'd0;
    localparam mode_t MODE_PUSH_BACK  = 3'd1;
    localparam mode_t MODE_POP_FRONT  = 3'd2;
    localparam mode_t MODE_POP_BACK   = 3'd3;
    localparam mode_t MODE_DUMP       = 3'd4;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } deq_state_t;

    typedef struct packed {
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    load_result;
        status_t res_status;
        logic    dump_start;
        logic    dump_emit;
    } deq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic dump_last;
    } deq_stat_t;

endpackage

>>> src/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  deq_pkg::mode_t    mode,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t cmd
);
    import deq_pkg::*;

    deq_state_t state_reg;
    deq_state_t state_next;
    logic       accept;

    assign in_stall = !((state_reg == ST_IDLE) && stat.out_free);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_DUMP) && !stat.empty)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (stat.out_free && stat.dump_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_result = 1'b1;
                    cmd.res_status  = STATUS_OK;
                    case (mode)
                        MODE_PUSH_FRONT:
                        begin
                            if (stat.full)
                            begin
                                cmd.res_status = STATUS_FULL;
                            end
                            else
                            begin
                                cmd.push_front = 1'b1;
                            end
                        end
                        MODE_PUSH_BACK:
                        begin
                            if (stat.full)
                            begin
                                cmd.res_status = STATUS_FULL;
                            end
                            else
                            begin
                                cmd.push_back = 1'b1;
                            end
                        end
                        MODE_POP_FRONT:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_front = 1'b1;
                            end
                        end
                        MODE_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_back = 1'b1;
                            end
                        end
                        MODE_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.load_result = 1'b0;
                                cmd.dump_start  = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.res_status = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                cmd.dump_emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/deq_dpath.sv
`timescale 1ns / 1ps
`include "double_ended_queue_macros.svh"

module deq_dpath
#(
    parameter int DEPTH = 32,
    parameter int IW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [deq_pkg::WORD_W-1:0]   value,
    input  deq_pkg::deq_cmd_t                   cmd,
    output deq_pkg::deq_stat_t                  stat,
    output logic                                out_valid,
    input  logic                                out_stall,
    output deq_pkg::status_t                    status,
    output logic signed [deq_pkg::WORD_W-1:0]   data,
    output logic [CW-1:0]                       occupancy,
    output logic                                last
);
    import deq_pkg::*;

    localparam logic [IW-1:0] IDX_MAX   = IW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic [IW-1:0] front_reg;
    logic [IW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [IW-1:0] rd_idx_reg;
    logic [IW-1:0] rd_idx_next;
    logic [CW-1:0] remain_reg;
    logic [CW-1:0] remain_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    status_t       status_reg;
    logic [WORD_W-1:0] data_reg;
    logic [CW-1:0] occ_reg;
    logic          last_reg;

    logic [IW-1:0] front_inc;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] rd_idx_inc;
    logic [IW:0]   back_sum;
    logic [IW-1:0] back_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    logic [IW-1:0] rd_addr;
    logic          rd_en;

    assign front_inc  = (front_reg == IDX_MAX) ? '0 : front_reg + 1'b1;
    assign front_dec  = (front_reg == '0) ? IDX_MAX : front_reg - 1'b1;
    assign rd_idx_inc = (rd_idx_reg == IDX_MAX) ? '0 : rd_idx_reg + 1'b1;
    assign back_sum   = {1'b0, front_reg} + (IW + 1)'(count_reg);
    assign back_addr  = (back_sum >= (IW + 1)'(DEPTH)) ?
                        IW'(back_sum - (IW + 1)'(DEPTH)) : back_sum[IW-1:0];

    assign wr_en   = cmd.push_front || cmd.push_back;
    assign wr_addr = cmd.push_front ? front_dec : back_addr;
    assign rd_en   = cmd.dump_start || cmd.dump_emit;
    assign rd_addr = cmd.dump_start ? front_reg : rd_idx_inc;

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        remain_next = remain_reg;
        if (cmd.push_front)
        begin
            front_next = front_dec;
        end
        if (cmd.pop_front)
        begin
            front_next = front_inc;
        end
        if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop_front || cmd.pop_back)
        begin
            count_next = count_reg - 1'b1;
        end
        if (rd_en)
        begin
            rd_idx_next = rd_addr;
        end
        if (cmd.dump_start)
        begin
            remain_next = count_reg;
        end
        else if (cmd.dump_emit)
        begin
            remain_next = remain_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.load_result || cmd.dump_emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            status_reg <= cmd.res_status;
            data_reg   <= '0;
            occ_reg    <= count_next;
            last_reg   <= 1'b1;
        end
        else if (cmd.dump_emit)
        begin
            status_reg <= STATUS_OK;
            data_reg   <= rdata_reg;
            occ_reg    <= count_reg;
            last_reg   <= stat.dump_last;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == COUNT_MAX);
    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.dump_last = (remain_reg == CW'(1));

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign occupancy = occ_reg;
    assign last      = last_reg;

    `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= COUNT_MAX)
    `DEQ_ASSERT_NOW(a_no_push_full, cmd.push_front || cmd.push_back, count_reg != COUNT_MAX)
    `DEQ_ASSERT_NOW(a_no_pop_empty, cmd.pop_front || cmd.pop_back, count_reg != '0)
    `DEQ_ASSERT_NEXT(a_dump_keeps_count, cmd.dump_emit, $stable(count_reg))
    `DEQ_ASSERT_NEXT(a_dump_last, cmd.dump_emit && stat.dump_last, out_valid_reg && last_reg)

endmodule

>>> src/double_ended_queue.sv
`timescale 1ns / 1ps
// Push, pop and undefined operations: one word in, one registered result word in the next cycle.
// These sustain one input word per cycle while the output side takes results.
// A dump stalls input until its last word is out; the store first reads the front element,
// then one element word per cycle is emitted via the single read port while out_stall is low.
// Reset clears the front index, the element count and the output valid; the store is not cleared.
module double_ended_queue
#(
    parameter int DEPTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  deq_pkg::mode_t                        mode,
    input  logic signed [deq_pkg::WORD_W-1:0]     value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output deq_pkg::status_t                      status,
    output logic signed [deq_pkg::WORD_W-1:0]     data,
    output logic [$clog2(DEPTH + 1)-1:0]          occupancy,
    output logic                                  last
);
    import deq_pkg::*;

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_dpath
    #(
        .DEPTH (DEPTH)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .occupancy (occupancy),
        .last      (last)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import deq_pkg::*;

    localparam int DEPTH = 32;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int WORD_COUNT = 230;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_AT_RESULT = 60;
    localparam int HOLD_CYCLES = 150;

    localparam mode_t MODE_SPARE_LO  = 3'd5;
    localparam mode_t MODE_SPARE_MID = 3'd6;
    localparam mode_t MODE_SPARE_HI  = 3'd7;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIX
    } burst_t;

    typedef struct packed {
        status_t                 status;
        logic signed [WORD_W-1:0] data;
        logic [OCC_W-1:0]        occupancy;
        logic                    last;
    } deq_result_t;

    typedef struct packed {
        mode_t                   op;
        logic signed [WORD_W-1:0] word;
        logic                    typed;
        status_t                 st;
        logic [OCC_W-1:0]        occ;
    } script_row_t;

    // Rows with typed set carry their single result; the others go through the predictor.
    localparam script_row_t SCRIPT [23] = '{
        '{MODE_POP_FRONT,  32'sh0000_0000, 1'b1, STATUS_EMPTY, 6'd0},
        '{MODE_POP_BACK,   32'sh0000_0000, 1'b1, STATUS_EMPTY, 6'd0},
        '{MODE_DUMP,       32'sh0000_0000, 1'b1, STATUS_EMPTY, 6'd0},
        '{MODE_SPARE_LO,   32'sh1234_5678, 1'b1, STATUS_OK,    6'd0},
        '{MODE_PUSH_FRONT, 32'sh7fff_ffff, 1'b1, STATUS_OK,    6'd1},
        '{MODE_PUSH_BACK,  32'sh8000_0000, 1'b1, STATUS_OK,    6'd2},
        '{MODE_SPARE_HI,   32'shffff_ffff, 1'b1, STATUS_OK,    6'd2},
        '{MODE_PUSH_FRONT, 32'sh0000_0000, 1'b0, STATUS_OK,    6'd0},
        '{MODE_PUSH_BACK,  32'shffff_ffff, 1'b0, STATUS_OK,    6'd0},
        '{MODE_PUSH_FRONT, 32'sh5555_5555, 1'b0, STATUS_OK,    6'd0},
        '{MODE_PUSH_BACK,  32'shaaaa_aaaa, 1'b0, STATUS_OK,    6'd0},
        '{MODE_DUMP,       32'sh0000_0000, 1'b0, STATUS_OK,    6'd0},
        '{MODE_POP_FRONT,  32'sh0000_0000, 1'b0, STATUS_OK,    6'd0},
        '{MODE_POP_BACK,   32'sh0000_0000, 1'b0, STATUS_OK,    6'd0},
        '{MODE_DUMP,       32'sh0000_0000, 1'b0, STATUS_OK,    6'd0},
        '{MODE_SPARE_MID,  32'sh0f0f_0f0f, 1'b1, STATUS_OK,    6'd4},
        '{MODE_POP_BACK,   32'sh0000_0000, 1'b0, STATUS_OK,    6'd0},
        '{MODE_POP_BACK,   32'sh0000_0000, 1'b0, STATUS_OK,    6'd0},
        '{MODE_POP_FRONT,  32'sh0000_0000, 1'b0, STATUS_OK,    6'd0},
        '{MODE_POP_FRONT,  32'sh0000_0000, 1'b1, STATUS_OK,    6'd0},
        '{MODE_POP_FRONT,  32'sh0000_0000, 1'b1, STATUS_EMPTY, 6'd0},
        '{MODE_PUSH_BACK,  32'sh0000_0001, 1'b0, STATUS_OK,    6'd0},
        '{MODE_DUMP,       32'sh0000_0000, 1'b0, STATUS_OK,    6'd0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    mode_t                    mode;
    logic signed [WORD_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    status_t                  status;
    logic signed [WORD_W-1:0] data;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;

    logic signed [WORD_W-1:0] ring [DEPTH];
    int                       ring_head;
    int                       ring_count;
    deq_result_t              step_results [$];
    deq_result_t              pending_results [$];
    int                       words_sent;
    int                       results_seen;
    int                       errors;
    int                       cycles;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .data(data),
        .occupancy(occupancy),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void predict_deque(mode_t op, logic signed [WORD_W-1:0] word);
        step_results.delete();
        case (op)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                if (ring_count >= DEPTH)
                begin
                    step_results.push_back(deq_result_t'{STATUS_FULL, '0,
                                                         OCC_W'(ring_count), 1'b1});
                end
                else
                begin
                    if (op == MODE_PUSH_FRONT)
                    begin
                        ring_head = (ring_head + DEPTH - 1) % DEPTH;
                        ring[ring_head] = word;
                    end
                    else
                    begin
                        ring[(ring_head + ring_count) % DEPTH] = word;
                    end
                    ring_count++;
                    step_results.push_back(deq_result_t'{STATUS_OK, '0,
                                                         OCC_W'(ring_count), 1'b1});
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK:
            begin
                if (ring_count == 0)
                begin
                    step_results.push_back(deq_result_t'{STATUS_EMPTY, '0, '0, 1'b1});
                end
                else
                begin
                    if (op == MODE_POP_FRONT)
                        ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                    step_results.push_back(deq_result_t'{STATUS_OK, '0,
                                                         OCC_W'(ring_count), 1'b1});
                end
            end
            MODE_DUMP:
            begin
                if (ring_count == 0)
                    step_results.push_back(deq_result_t'{STATUS_EMPTY, '0, '0, 1'b1});
                for (int i = 0; i < ring_count; i++)
                begin
                    step_results.push_back(deq_result_t'{STATUS_OK,
                                                         ring[(ring_head + i) % DEPTH],
                                                         OCC_W'(ring_count),
                                                         i == ring_count - 1});
                end
            end
            default:
            begin
                step_results.push_back(deq_result_t'{STATUS_OK, '0,
                                                     OCC_W'(ring_count), 1'b1});
            end
        endcase
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return 32'shffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic pause_input(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_word(mode_t op, logic signed [WORD_W-1:0] word);
        in_valid <= 1'b1;
        mode <= op;
        value <= word;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        int hold_left;
        int phase_left;
        int style;
        logic stall_now;
        bit hold_done;
        deq_result_t want;

        hold_left = 0;
        phase_left = 0;
        style = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d data %h",
                             $time, status, data);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(status));
                    check_field("data", want.data, data);
                    check_field("occupancy", WORD_W'(want.occupancy), WORD_W'(occupancy));
                    check_field("last", WORD_W'(want.last), WORD_W'(last));
                end
                results_seen++;
            end

            if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            stall_now = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_now = 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    style = $urandom_range(0, 2);
                    phase_left = $urandom_range(20, 100);
                end
                phase_left--;
                if (style == 1)
                    stall_now = ($urandom_range(0, 4) == 0);
                else if (style == 2)
                    stall_now = ($urandom_range(0, 9) < 6);
                if (style != 0 && $urandom_range(0, 299) == 0)
                    hold_left = $urandom_range(20, 80);
            end
            out_stall <= stall_now;
        end
    end

    initial
    begin
        burst_t kind;
        int span;
        int bursts;
        int gap;
        int r;
        bit steady;
        mode_t op;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        mode <= MODE_PUSH_FRONT;
        value <= '0;
        ring_head = 0;
        ring_count = 0;
        words_sent = 0;
        bursts = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[k])
        begin
            gap = draw_gap();
            if (gap > 0)
                pause_input(gap);
            send_word(SCRIPT[k].op, SCRIPT[k].word);
            predict_deque(SCRIPT[k].op, SCRIPT[k].word);
            if (SCRIPT[k].typed)
                pending_results.push_back(deq_result_t'{SCRIPT[k].st, '0, SCRIPT[k].occ, 1'b1});
            else
                foreach (step_results[j]) pending_results.push_back(step_results[j]);
        end

        while (words_sent < WORD_COUNT)
        begin
            if (bursts == 0)
            begin
                kind = BURST_FILL;
                span = 45;
            end
            else
            begin
                kind = burst_t'($urandom_range(0, 2));
                span = (kind == BURST_FILL) ? $urandom_range(20, 45) : $urandom_range(5, 40);
            end
            steady = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < span && words_sent < WORD_COUNT; j++)
            begin
                r = $urandom_range(0, 99);
                case (kind)
                    BURST_FILL:
                        op = (r < 94) ? ($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT)
                                      : MODE_DUMP;
                    BURST_DRAIN:
                        op = (r < 88) ? ($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT)
                                      : MODE_DUMP;
                    default:
                    begin
                        if (r < 40)
                            op = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
                        else if (r < 80)
                            op = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
                        else if (r < 92)
                            op = MODE_DUMP;
                        else
                            op = mode_t'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
                    end
                endcase
                if (!steady)
                begin
                    gap = draw_gap();
                    if (gap > 0)
                        pause_input(gap);
                end
                send_word(op, draw_word());
                predict_deque(op, value);
                foreach (step_results[k]) pending_results.push_back(step_results[k]);
            end
            bursts++;
            if (bursts == 1 || $urandom_range(0, 5) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
